// ----- rtl/core/nalsc_pkg.sv -----
// Shared types and constants for the NAL unit start code scanner.
package nalsc_pkg;

	localparam int POS_W      = 24;                   // byte position width
	localparam int EXT_W      = POS_W + 1;            // position width with one carry bit
	localparam int FIELD_W    = 24;                   // width of counts and offsets in a record
	localparam int LEN_W      = 24;                   // buffer length register width
	localparam int NUM_TYPES  = 32;                   // number of NAL unit type counters
	localparam int TYPE_W     = $clog2(NUM_TYPES);    // histogram index width
	localparam int UTYPE_W    = 5;                    // unit type field width
	localparam int PREFIX_W   = 3;                    // prefix length field width

	localparam logic [PREFIX_W-1:0] PREFIX_NONE  = 3'd0;
	localparam logic [PREFIX_W-1:0] PREFIX_SHORT = 3'd3;
	localparam logic [PREFIX_W-1:0] PREFIX_LONG  = 3'd4;

	localparam logic [UTYPE_W-1:0] IDR_TYPE = 5'd5;
	localparam logic [LEN_W-1:0]   LEN_RESET = 24'd5;

	// Distance in bytes from a candidate start to the byte that decides it.
	localparam int START_LAG = 3;

	// Request from the scanner to the per-type counters.
	typedef struct packed {
		logic              clr;    // drop all counts (end of buffer)
		logic              inc;    // count one more unit of utype
		logic [TYPE_W-1:0] utype;
	} hist_req_t;

endpackage

// ----- rtl/core/nalsc_match.sv -----
// Start code pattern match on the three held bytes and the current byte.
module nalsc_match import nalsc_pkg::*; (
	input  logic [23:0]         window,
	input  logic [7:0]          data_byte,
	output logic [PREFIX_W-1:0] prefix
);

	logic two_zero;

	assign two_zero = (window[23:16] == 8'h00) && (window[15:8] == 8'h00);

	// The four byte code takes precedence over the three byte one.
	always_comb begin
		if (two_zero && (window[7:0] == 8'h00) && (data_byte == 8'h01)) begin
			prefix = PREFIX_LONG;
		end else if (two_zero && (window[7:0] == 8'h01)) begin
			prefix = PREFIX_SHORT;
		end else begin
			prefix = PREFIX_NONE;
		end
	end

endmodule

// ----- rtl/core/nalsc_hist.sv -----
// Per-type unit counters with valid bits, cleared at once at buffer end.
module nalsc_hist import nalsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  hist_req_t          req,
	output logic [FIELD_W-1:0] count_next
);

	logic [FIELD_W-1:0]   cnt_q [NUM_TYPES];
	logic [NUM_TYPES-1:0] vld_q;
	logic [FIELD_W-1:0]   cur;

	assign cur        = vld_q[req.utype] ? cnt_q[req.utype] : '0;
	assign count_next = cur + FIELD_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr) begin
			vld_q <= '0;
		end else if (req.inc) begin
			vld_q[req.utype] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.inc) begin
			cnt_q[req.utype] <= count_next;
		end
	end

endmodule

// ----- rtl/core/nal_unit_start_code_scanner_unit.sv -----
// Top level of the H.264 Annex B NAL unit start code scanner.
//
// The scanner takes one buffer byte per word on the input channel and sends one record per NAL
// unit on the output channel. A start code (00 00 00 01 first, then 00 00 01) is recognized on
// its fourth byte; the record of a unit leaves when the next start code is seen, and the record
// of the last unit leaves with the final byte of the buffer (position buffer_length-1). After
// the final byte all scan state and the per-type counts drop to zero for the next buffer.
// Throughput is one byte per clock while the output side does not stall: a byte sits in the
// input register, passes through the match, compare and counter-update logic and lands in
// the result register. The input stalls only while a record waits in the result register
// and the output side stalls. Write buffer_length only while no bytes are in flight; a new
// value takes effect at the next byte.
module nal_unit_start_code_scanner_unit import nalsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [LEN_W-1:0]    cfg_wr_data,
	// byte input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	// record output
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FIELD_W-1:0]  unit_index,
	output logic [FIELD_W-1:0]  payload_offset,
	output logic [FIELD_W-1:0]  payload_length,
	output logic [PREFIX_W-1:0] prefix_len,
	output logic [UTYPE_W-1:0]  unit_type,
	output logic                is_idr,
	output logic [FIELD_W-1:0]  same_type_count
);

	// configuration
	logic [LEN_W-1:0]    buf_len_q;

	// input stage
	logic                v_s1;
	logic [7:0]          data_s1;

	// scan state
	logic [23:0]         recent_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    earliest_q;
	logic [POS_W-1:0]    pend_start_q;
	logic [PREFIX_W-1:0] pend_prefix_q;
	logic [UTYPE_W-1:0]  pend_type_q;
	logic                pend_valid_q;
	logic [FIELD_W-1:0]  units_q;

	// per-byte logic
	logic                adv;
	logic [PREFIX_W-1:0] match_prefix;
	logic [POS_W-1:0]    cand_s;
	logic [EXT_W-1:0]    pos_ext;
	logic [EXT_W-1:0]    len_ext;
	logic                hdr_hit;
	logic [UTYPE_W-1:0]  type_cur;
	logic                cand;
	logic                match;
	logic                final_byte;
	logic                emit_a;
	logic                emit_b;
	logic                emit;
	logic [POS_W-1:0]    nx_start;
	logic [PREFIX_W-1:0] nx_prefix;
	logic [UTYPE_W-1:0]  nx_type;
	logic [POS_W-1:0]    rec_start;
	logic [PREFIX_W-1:0] rec_prefix;
	logic [UTYPE_W-1:0]  rec_type;
	logic [EXT_W-1:0]    rec_pay;
	logic [EXT_W-1:0]    rec_end;
	logic [EXT_W-1:0]    rec_len;
	logic [FIELD_W-1:0]  cnt_next;
	hist_req_t           hreq;

	// The result register is free or being emptied: the held byte may go through.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = v_s1 && !adv;

	// buffer length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			buf_len_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	nalsc_match u_match (
		.window    (recent_q),
		.data_byte (data_s1),
		.prefix    (match_prefix)
	);

	always_comb begin
		pos_ext = {1'b0, pos_q};
		len_ext = EXT_W'(buf_len_q);
		cand_s  = pos_q - POS_W'(START_LAG);

		// The header byte of the open unit updates its type on arrival.
		hdr_hit  = pend_valid_q && (pos_q == (pend_start_q + POS_W'(pend_prefix_q)));
		type_cur = hdr_hit ? data_s1[UTYPE_W-1:0] : pend_type_q;

		// A candidate start needs four bytes seen, must not overlap the last
		// header, and must leave room for the code and a header in the buffer.
		cand  = (pos_q >= POS_W'(START_LAG)) && (cand_s >= earliest_q)
			&& ((pos_ext + EXT_W'(2)) <= len_ext);
		match = cand && (match_prefix != PREFIX_NONE);

		final_byte = (pos_ext + EXT_W'(1)) >= len_ext;

		// Open unit after this byte.
		nx_start  = match ? cand_s : pend_start_q;
		nx_prefix = match ? match_prefix : pend_prefix_q;
		if (match) begin
			nx_type = (match_prefix == PREFIX_SHORT) ? data_s1[UTYPE_W-1:0] : '0;
		end else begin
			nx_type = type_cur;
		end

		// Close the open unit at a new start code, or at the buffer end.
		emit_a = match && pend_valid_q;
		emit_b = final_byte && (pend_valid_q || match) && !emit_a;
		emit   = emit_a || emit_b;

		rec_start  = emit_a ? pend_start_q : nx_start;
		rec_prefix = emit_a ? pend_prefix_q : nx_prefix;
		rec_type   = emit_a ? type_cur : nx_type;
		rec_pay    = EXT_W'(rec_start) + EXT_W'(rec_prefix) + EXT_W'(1);
		rec_end    = emit_a ? EXT_W'(cand_s) : len_ext;
		rec_len    = (rec_end >= rec_pay) ? (rec_end - rec_pay) : '0;

		hreq.clr   = v_s1 && adv && final_byte;
		hreq.inc   = v_s1 && adv && emit;
		hreq.utype = TYPE_W'(rec_type);
	end

	nalsc_hist u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (hreq),
		.count_next (cnt_next)
	);

	// scan state: advance one byte, or drop everything at the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q      <= '0;
			pos_q         <= '0;
			earliest_q    <= '0;
			pend_start_q  <= '0;
			pend_prefix_q <= PREFIX_NONE;
			pend_type_q   <= '0;
			pend_valid_q  <= 1'b0;
			units_q       <= '0;
		end else if (v_s1 && adv) begin
			if (final_byte) begin
				recent_q      <= '0;
				pos_q         <= '0;
				earliest_q    <= '0;
				pend_start_q  <= '0;
				pend_prefix_q <= PREFIX_NONE;
				pend_type_q   <= '0;
				pend_valid_q  <= 1'b0;
				units_q       <= '0;
			end else begin
				recent_q      <= {recent_q[15:0], data_s1};
				pos_q         <= pos_q + POS_W'(1);
				pend_start_q  <= nx_start;
				pend_prefix_q <= nx_prefix;
				pend_type_q   <= nx_type;
				pend_valid_q  <= pend_valid_q || match;
				if (match) begin
					earliest_q <= cand_s + POS_W'(match_prefix) + POS_W'(1);
				end
				if (emit) begin
					units_q <= units_q + FIELD_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && emit) begin
			unit_index      <= units_q;
			payload_offset  <= FIELD_W'(rec_pay);
			payload_length  <= FIELD_W'(rec_len);
			prefix_len      <= rec_prefix;
			unit_type       <= rec_type;
			is_idr          <= (rec_type == IDR_TYPE);
			same_type_count <= cnt_next;
		end
	end

	// A record always carries a real start code length.
	a_prefix_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((prefix_len == PREFIX_SHORT) || (prefix_len == PREFIX_LONG)))
		else $error("record with illegal prefix length");

	// The unit being reported is counted, so its type count is never zero.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (same_type_count != '0))
		else $error("record with zero type count");

	// After the final byte the scanner is back at the buffer start with no open unit.
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv && final_byte) |=> ((pos_q == '0) && !pend_valid_q && (units_q == '0)))
		else $error("scan state not cleared after final byte");

	// A held record with the output stalled must not let a byte through.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(unit_index)))
		else $error("pending record overwritten");

endmodule
